FILE: src/lpse_pkg.sv
// Shared types and constants for the LED pixel symbol encoder.
package lpse_pkg;

	localparam int BitsPerByte     = 8;
	localparam int BytesPerPixel   = 3;
	localparam int SymbolsPerPixel = BitsPerByte * BytesPerPixel;
	localparam int PixelWidth      = BitsPerByte * BytesPerPixel;
	localparam int DurWidth        = 15;
	localparam int BrightWidth     = 9;
	localparam int CfgIndexWidth   = 3;
	localparam int CfgDataWidth    = 15;
	localparam int PosWidth        = 5;
	localparam int ByteSelWidth    = 2;
	localparam int BitSelWidth     = 3;

	localparam logic [BrightWidth-1:0] BrightFull = 9'd256;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_ZERO_FIRST  = 3'd0,
		REG_ZERO_SECOND = 3'd1,
		REG_ONE_FIRST   = 3'd2,
		REG_ONE_SECOND  = 3'd3,
		REG_HIGH_LOW    = 3'd4,
		REG_MSB_LEAD    = 3'd5,
		REG_BRIGHTNESS  = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [DurWidth-1:0]    zero_first;
		logic [DurWidth-1:0]    zero_second;
		logic [DurWidth-1:0]    one_first;
		logic [DurWidth-1:0]    one_second;
		logic                   high_then_low;
		logic                   msb_lead;
		logic [BrightWidth-1:0] brightness;
	} cfg_t;

	// One scaled pixel; the first wire byte sits in the lowest bits.
	typedef struct packed {
		logic                  last;
		logic [PixelWidth-1:0] bytes;
	} pixel_t;

	typedef struct packed {
		logic   valid;
		pixel_t data;
	} queue_rd_t;

endpackage

FILE: src/lpse_front.sv
// Front end: accepts pixels and scales each byte by the brightness factor.
module lpse_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpse_pkg::PixelWidth-1:0] in_bytes,
	input  logic                          in_last,
	input  logic [lpse_pkg::BrightWidth-1:0] brightness,
	output logic                          push_valid,
	input  logic                          push_ready,
	output lpse_pkg::pixel_t              push_data
);

	logic                                 valid_s1;
	lpse_pkg::pixel_t                     data_s1;
	logic [lpse_pkg::BrightWidth-1:0]     factor;
	logic [lpse_pkg::PixelWidth-1:0]      scaled;

	// Factors above full scale saturate to full scale.
	assign factor = (brightness > lpse_pkg::BrightFull) ? lpse_pkg::BrightFull : brightness;

	always_comb begin
		logic [lpse_pkg::BitsPerByte+lpse_pkg::BrightWidth-1:0] prod;
		scaled = '0;
		for (int b = 0; b < lpse_pkg::BytesPerPixel; b++) begin
			prod = {{lpse_pkg::BrightWidth{1'b0}}, in_bytes[b*lpse_pkg::BitsPerByte +:
				lpse_pkg::BitsPerByte]} * {{lpse_pkg::BitsPerByte{1'b0}}, factor};
			scaled[b*lpse_pkg::BitsPerByte +: lpse_pkg::BitsPerByte] =
				prod[lpse_pkg::BitsPerByte +: lpse_pkg::BitsPerByte];
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.bytes <= scaled;
			data_s1.last  <= in_last;
		end
	end

endmodule

FILE: src/lpse_queue.sv
// Two-entry queue of scaled pixels between the front and back ends.
module lpse_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  lpse_pkg::pixel_t     push_data,
	output lpse_pkg::queue_rd_t  rd,
	input  logic                 pop
);

	lpse_pkg::pixel_t mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && (count_q != 2'd0);
	assign rd.valid   = (count_q != 2'd0);
	assign rd.data    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_data;
	end

endmodule

FILE: src/lpse_back.sv
// Back end: serializes one pixel into 24 pulse symbols behind an output register.
module lpse_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpse_pkg::cfg_t                cfg,
	input  lpse_pkg::queue_rd_t           rd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpse_pkg::DurWidth-1:0] one_length,
	output logic                          one_level,
	output logic [lpse_pkg::DurWidth-1:0] two_length,
	output logic                          two_level,
	output logic                          done,
	output logic                          frame_end
);

	localparam logic [lpse_pkg::PosWidth-1:0] LastPos =
		lpse_pkg::PosWidth'(lpse_pkg::SymbolsPerPixel - 1);

	logic                                busy_q;
	logic [lpse_pkg::PosWidth-1:0]       pos_q;
	lpse_pkg::pixel_t                    cur_q;
	logic                                out_valid_q;
	logic                                load;
	logic                                final_sym;
	logic [lpse_pkg::BitsPerByte-1:0]    cur_byte;
	logic [lpse_pkg::BitSelWidth-1:0]    step;
	logic [lpse_pkg::BitSelWidth-1:0]    bit_idx;
	logic                                sym_bit;

	assign load      = !out_valid_q || out_ready;
	assign final_sym = (pos_q == LastPos);
	// Refill at the final symbol so pixels follow without a gap.
	assign pop       = load && rd.valid && (!busy_q || final_sym);

	assign cur_byte = cur_q.bytes[pos_q[lpse_pkg::PosWidth-1 -: lpse_pkg::ByteSelWidth] *
		lpse_pkg::BitsPerByte +: lpse_pkg::BitsPerByte];
	assign step     = pos_q[lpse_pkg::BitSelWidth-1:0];
	assign bit_idx  = cfg.msb_lead ? ~step : step;
	assign sym_bit  = cur_byte[bit_idx];

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= busy_q;
			if (busy_q && !final_sym) begin
				pos_q <= pos_q + 1'b1;
			end else begin
				pos_q  <= '0;
				busy_q <= rd.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= rd.data;
		if (load && busy_q) begin
			one_length <= sym_bit ? cfg.one_first : cfg.zero_first;
			two_length <= sym_bit ? cfg.one_second : cfg.zero_second;
			one_level  <= cfg.high_then_low;
			two_level  <= ~cfg.high_then_low;
			done       <= final_sym;
			frame_end  <= final_sym && cur_q.last;
		end
	end

endmodule

FILE: src/led_pixel_symbol_encoder.sv
// Top level of the LED pixel symbol encoder: configuration registers and stream ports.
// Path: an accepted pixel passes the front end register, the queue, the back end's pixel
// register and the output register before its first symbol shows on m_tvalid.
// Throughput: one symbol per cycle while m_tready stays high, set by the back end's symbol
// counter feeding the output register; the front end and queue hold up to three pixels.
// Reset: arst_n clears all handshake state at once and loads the register defaults.
module led_pixel_symbol_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // color_first[7:0], color_second[15:8], color_third[23:16]
	input  logic        s_tlast,  // last_pixel
	// Symbol output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // phase_one_length[14:0], phase_one_level[15],
	                              // phase_two_length[30:16], phase_two_level[31]
	output logic        m_tlast,  // pixel_done
	output logic        m_tuser,  // frame_end
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [lpse_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [lpse_pkg::CfgDataWidth-1:0]  cfg_data
);

	// All configuration lives here; the front end reads only the brightness, the
	// back end the durations, levels and bit order. The user must write only while
	// idle; the block does not enforce it, and both ends read the registers directly.
	lpse_pkg::cfg_t      cfg_q;

	logic                push_valid;
	logic                push_ready;
	lpse_pkg::pixel_t    push_data;
	lpse_pkg::queue_rd_t rd;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_first    <= 15'd4;
			cfg_q.zero_second   <= 15'd8;
			cfg_q.one_first     <= 15'd8;
			cfg_q.one_second    <= 15'd4;
			cfg_q.high_then_low <= 1'b1;
			cfg_q.msb_lead      <= 1'b1;
			cfg_q.brightness    <= lpse_pkg::BrightFull;
		end else if (cfg_we) begin
			case (cfg_index)
				lpse_pkg::REG_ZERO_FIRST:  cfg_q.zero_first    <= cfg_data;
				lpse_pkg::REG_ZERO_SECOND: cfg_q.zero_second   <= cfg_data;
				lpse_pkg::REG_ONE_FIRST:   cfg_q.one_first     <= cfg_data;
				lpse_pkg::REG_ONE_SECOND:  cfg_q.one_second    <= cfg_data;
				lpse_pkg::REG_HIGH_LOW:    cfg_q.high_then_low <= cfg_data[0];
				lpse_pkg::REG_MSB_LEAD:    cfg_q.msb_lead      <= cfg_data[0];
				lpse_pkg::REG_BRIGHTNESS:  cfg_q.brightness    <=
					cfg_data[lpse_pkg::BrightWidth-1:0];
				default: ;  // Indexes past the register list are ignored.
			endcase
		end
	end

	// The front end scales the three bytes as it accepts the pixel.
	lpse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_bytes   (s_tdata),
		.in_last    (s_tlast),
		.brightness (cfg_q.brightness),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// The queue lets a new pixel be taken while the previous one is still serialized.
	lpse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.rd         (rd),
		.pop        (pop)
	);

	// The back end walks 24 bit positions and drives one symbol per transaction.
	lpse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.rd         (rd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.one_length (m_tdata[14:0]),
		.one_level  (m_tdata[15]),
		.two_length (m_tdata[30:16]),
		.two_level  (m_tdata[31]),
		.done       (m_tlast),
		.frame_end  (m_tuser)
	);

endmodule

FILE: src/lpse_checker.sv
// Port-level checks for the LED pixel symbol encoder, bound to the top level.
module lpse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// The two phases of a symbol always sit at opposite line levels.
	a_levels_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15] != m_tdata[31]))
		else $error("symbol phases share one level");

	// A frame end can only come on the last symbol of a pixel.
	a_frame_on_pixel_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("frame end without pixel end");

	// A held symbol does not change under backpressure.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled symbol changed");

	// Two pixel ends never come back to back: each pixel has 24 symbols.
	a_pixel_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tlast && !$stable(m_tdata)))
		else $error("pixel end followed by another pixel end");

endmodule

bind led_pixel_symbol_encoder lpse_checker u_lpse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: test/lpse_symbol_checker.sv
// Stream monitor for the LED pixel symbol encoder: predicts every symbol and compares it.
module lpse_symbol_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [23:0]                        s_tdata,
	input  logic                               s_tlast,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [31:0]                        m_tdata,
	input  logic                               m_tlast,
	input  logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [lpse_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [lpse_pkg::CfgDataWidth-1:0]  cfg_data,
	output int                                 fail_count,
	output int                                 pending_symbols,
	output int                                 symbols_checked,
	output int                                 pixels_taken,
	output int                                 frames_ended
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [lpse_pkg::DurWidth-1:0] first_length;
		logic                          first_level;
		logic [lpse_pkg::DurWidth-1:0] second_length;
		logic                          second_level;
		logic                          pixel_done;
		logic                          frame_end;
	} symbol_t;

	lpse_pkg::cfg_t settings;
	symbol_t        expected_symbols[$];

	int failures  = 0;
	int pending   = 0;
	int checked   = 0;
	int pixels    = 0;
	int frames    = 0;

	assign fail_count      = failures;
	assign pending_symbols = pending;
	assign symbols_checked = checked;
	assign pixels_taken    = pixels;
	assign frames_ended    = frames;

	// Factors above full scale behave as full scale.
	function automatic logic [7:0] scale_byte(input logic [7:0] value,
			input logic [lpse_pkg::BrightWidth-1:0] factor);
		logic [lpse_pkg::BrightWidth-1:0] clipped;
		logic [16:0]                      product;
		clipped = (factor > lpse_pkg::BrightFull) ? lpse_pkg::BrightFull : factor;
		product = value * clipped;
		return product[15:8];
	endfunction

	task automatic predict_pixel(input logic [lpse_pkg::PixelWidth-1:0] colors,
			input logic last_pixel);
		logic [7:0] scaled [lpse_pkg::BytesPerPixel];
		symbol_t    sym;
		int         byte_sel;
		int         bit_sel;
		logic       bit_value;
		for (int b = 0; b < lpse_pkg::BytesPerPixel; b++) begin
			scaled[b] = scale_byte(colors[b*lpse_pkg::BitsPerByte +: lpse_pkg::BitsPerByte],
				settings.brightness);
		end
		for (int k = 0; k < lpse_pkg::SymbolsPerPixel; k++) begin
			byte_sel  = k / lpse_pkg::BitsPerByte;
			bit_sel   = settings.msb_lead ?
				lpse_pkg::BitsPerByte - 1 - k % lpse_pkg::BitsPerByte :
				k % lpse_pkg::BitsPerByte;
			bit_value = scaled[byte_sel][bit_sel];
			sym.first_length  = bit_value ? settings.one_first : settings.zero_first;
			sym.second_length = bit_value ? settings.one_second : settings.zero_second;
			sym.first_level   = settings.high_then_low;
			sym.second_level  = ~settings.high_then_low;
			sym.pixel_done    = (k == lpse_pkg::SymbolsPerPixel - 1);
			sym.frame_end     = sym.pixel_done && last_pixel;
			expected_symbols.push_back(sym);
		end
	endtask

	task automatic check_field(input string name, input logic [lpse_pkg::DurWidth-1:0] want,
			input logic [lpse_pkg::DurWidth-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		symbol_t want;
		if (!arst_n) begin
			settings.zero_first    = 15'd4;
			settings.zero_second   = 15'd8;
			settings.one_first     = 15'd8;
			settings.one_second    = 15'd4;
			settings.high_then_low = 1'b1;
			settings.msb_lead      = 1'b1;
			settings.brightness    = lpse_pkg::BrightFull;
			expected_symbols.delete();
		end else begin
			// Output side first, so a pixel taken at this edge cannot match its own symbols.
			if (m_tvalid && m_tready) begin
				if (expected_symbols.size() == 0) begin
					$error("symbol transaction with nothing expected: tdata %h", m_tdata);
					failures++;
				end else begin
					want = expected_symbols.pop_front();
					check_field("phase_one_length", want.first_length, m_tdata[14:0]);
					check_field("phase_one_level", want.first_level, m_tdata[15]);
					check_field("phase_two_length", want.second_length, m_tdata[30:16]);
					check_field("phase_two_level", want.second_level, m_tdata[31]);
					check_field("pixel_done", want.pixel_done, m_tlast);
					check_field("frame_end", want.frame_end, m_tuser);
					checked++;
					if (want.frame_end) begin
						frames++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_pixel(s_tdata, s_tlast);
				pixels++;
			end
			if (cfg_we) begin
				case (lpse_pkg::reg_index_t'(cfg_index))
					lpse_pkg::REG_ZERO_FIRST:
						settings.zero_first = cfg_data[lpse_pkg::DurWidth-1:0];
					lpse_pkg::REG_ZERO_SECOND:
						settings.zero_second = cfg_data[lpse_pkg::DurWidth-1:0];
					lpse_pkg::REG_ONE_FIRST:
						settings.one_first = cfg_data[lpse_pkg::DurWidth-1:0];
					lpse_pkg::REG_ONE_SECOND:
						settings.one_second = cfg_data[lpse_pkg::DurWidth-1:0];
					lpse_pkg::REG_HIGH_LOW:
						settings.high_then_low = cfg_data[0];
					lpse_pkg::REG_MSB_LEAD:
						settings.msb_lead = cfg_data[0];
					lpse_pkg::REG_BRIGHTNESS:
						settings.brightness = cfg_data[lpse_pkg::BrightWidth-1:0];
					default: begin
					end
				endcase
			end
		end
		pending = expected_symbols.size();
	end

endmodule

FILE: test/testbench.sv
// Top of the encoder testbench: clock, reset, pixel and register stimulus, and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HalfPeriod    = 10;
	localparam int ResetCycles   = 8;
	// A pixel passes front, queue and back end registers before its first symbol; keep a wide margin.
	localparam int DrainCycles   = 12;
	// Slowest run: roughly 330 pixels x 24 symbols at widest sink gaps; allow five times that.
	localparam int LimitCycles   = 600_000;
	localparam int HoldCycles    = 300;
	localparam int RandomPhases  = 10;
	localparam int PhasePixels   = 30;
	localparam int SqueezePhase  = 2;
	// Index past the last register; writes to it must change nothing.
	localparam logic [lpse_pkg::CfgIndexWidth-1:0] RegUnused = 3'd7;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [23:0]                        s_tdata   = '0;  // color_first, color_second, color_third
	logic                               s_tlast   = 1'b0; // last_pixel
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [31:0]                        m_tdata;   // phase_one_length, phase_one_level,
	                                               // phase_two_length, phase_two_level
	logic                               m_tlast;   // pixel_done
	logic                               m_tuser;   // frame_end
	logic                               cfg_we    = 1'b0;
	logic [lpse_pkg::CfgIndexWidth-1:0] cfg_index = '0;
	logic [lpse_pkg::CfgDataWidth-1:0]  cfg_data  = '0;

	int fail_count;
	int pending_symbols;
	int symbols_checked;
	int pixels_taken;
	int frames_ended;

	// Idle limits of the two sides; they change from phase to phase.
	int source_gap_max    = 0;
	int sink_gap_max      = 0;
	// A nonzero value asks the symbol sink for one long hold-off.
	int sink_hold_cycles  = 0;
	int phases_done       = 0;

	always #HalfPeriod clk = ~clk;

	led_pixel_symbol_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lpse_symbol_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_symbols (pending_symbols),
		.symbols_checked (symbols_checked),
		.pixels_taken    (pixels_taken),
		.frames_ended    (frames_ended)
	);

	// Offers one pixel after a random gap and returns at the edge where the transaction
	// completes. A back-to-back pixel keeps tvalid high, so it is never lowered and raised
	// within one time step.
	task automatic send_pixel(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] third, input logic last_pixel);
		int gap;
		gap = $urandom_range(0, source_gap_max);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {third, second, first};
		s_tlast  <= last_pixel;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	// Register writes are one cycle each; the port has no handshake.
	task automatic write_reg(input logic [lpse_pkg::CfgIndexWidth-1:0] index,
			input logic [lpse_pkg::CfgDataWidth-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Ends a phase: stop offering, wait for every predicted symbol, then let the pipeline
	// run empty for a while so stray symbols would still be caught before the next write.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_symbols != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		phases_done++;
	endtask

	// Durations lean toward the extremes and short values, with the rest spread over the range.
	function automatic logic [lpse_pkg::CfgDataWidth-1:0] pick_duration();
		case ($urandom_range(0, 5))
			0: return 15'h0000;
			1: return 15'h7FFF;
			2: return 15'($urandom_range(1, 16));
			default: return 15'($urandom);
		endcase
	endfunction

	// Brightness covers zero, one, full scale, values beyond full scale and the normal range.
	// The bits above the register are always random, since the block must drop them.
	function automatic logic [lpse_pkg::CfgDataWidth-1:0] pick_brightness();
		logic [lpse_pkg::BrightWidth-1:0] level;
		case ($urandom_range(0, 7))
			0: level = 9'd0;
			1: level = 9'd1;
			2: level = lpse_pkg::BrightFull;
			3: level = 9'($urandom_range(257, 511));
			default: level = 9'($urandom_range(1, 256));
		endcase
		return {6'($urandom), level};
	endfunction

	function automatic int pick_gap_limit();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 14;
		endcase
	endfunction

	// One random phase: a fresh setting of every register, then a run of random pixels.
	// In the squeeze phase the source never idles and the sink holds off once for a long
	// stretch, so the internal queue fills and s_tready has to drop.
	task automatic run_random_phase(input int pixel_count, input logic squeeze);
		write_reg(lpse_pkg::REG_ZERO_FIRST, pick_duration());
		write_reg(lpse_pkg::REG_ZERO_SECOND, pick_duration());
		write_reg(lpse_pkg::REG_ONE_FIRST, pick_duration());
		write_reg(lpse_pkg::REG_ONE_SECOND, pick_duration());
		write_reg(lpse_pkg::REG_HIGH_LOW, 15'($urandom));
		write_reg(lpse_pkg::REG_MSB_LEAD, 15'($urandom));
		write_reg(lpse_pkg::REG_BRIGHTNESS, pick_brightness());
		if ($urandom_range(0, 3) == 0) begin
			write_reg(RegUnused, 15'($urandom));
		end
		source_gap_max = squeeze ? 0 : pick_gap_limit();
		sink_gap_max   = pick_gap_limit();
		if (squeeze) begin
			sink_hold_cycles = HoldCycles;
		end
		repeat (pixel_count) begin
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
		end
		settle();
	endtask

	// Symbol sink: after every symbol transaction it drops tready for a random number of
	// cycles, or once for the long hold-off when the stimulus asks for it. The hold-off is
	// counted here, independently of the source.
	initial begin : symbol_sink
		int gap;
		forever begin
			if (sink_hold_cycles != 0) begin
				gap = sink_hold_cycles;
				sink_hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, sink_gap_max);
			end
			if (gap != 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : stimulus
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: all-zero and all-one pixels and alternating bit patterns,
		// with and without the frame end.
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'h80, 8'h01, 8'hA5, 1'b0);
		send_pixel(8'h7F, 8'hFE, 8'h5A, 1'b1);
		settle();

		// Extreme durations, least significant bit first and low-then-high levels. The
		// one-bit flags are written with their low bit clear and other bits set, so only
		// the low bit may count.
		write_reg(lpse_pkg::REG_ZERO_FIRST, 15'h0000);
		write_reg(lpse_pkg::REG_ZERO_SECOND, 15'h7FFF);
		write_reg(lpse_pkg::REG_ONE_FIRST, 15'h7FFF);
		write_reg(lpse_pkg::REG_ONE_SECOND, 15'h0000);
		write_reg(lpse_pkg::REG_HIGH_LOW, 15'h7FFE);
		write_reg(lpse_pkg::REG_MSB_LEAD, 15'h4000);
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'h0100);
		send_pixel(8'h01, 8'h80, 8'hC3, 1'b1);
		send_pixel(8'hFF, 8'h00, 8'h55, 1'b0);
		settle();

		// Brightness zero turns every bit into a zero bit.
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'd0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		settle();

		// Brightness one keeps nothing but a zero byte either.
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'd1);
		send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
		settle();

		// Factors above full scale saturate; the all-ones write also checks that the bits
		// above the nine-bit register are dropped.
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'h7FFF);
		write_reg(lpse_pkg::REG_HIGH_LOW, 15'h0001);
		write_reg(lpse_pkg::REG_MSB_LEAD, 15'h0001);
		send_pixel(8'hAA, 8'h55, 8'hFF, 1'b1);
		settle();
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'd257);
		send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
		settle();

		// A write past the last register must leave every setting alone.
		write_reg(RegUnused, 15'h7FFF);
		write_reg(lpse_pkg::REG_BRIGHTNESS, 15'd128);
		send_pixel(8'hFF, 8'h81, 8'h7E, 1'b1);
		send_pixel(8'h03, 8'hC0, 8'h99, 1'b0);
		settle();

		for (int phase = 0; phase < RandomPhases; phase++) begin
			run_random_phase(PhasePixels, phase == SqueezePhase);
		end

		$display("Checked %0d symbols from %0d pixels (%0d frame ends) over %0d settings,",
			symbols_checked, pixels_taken, frames_ended, phases_done);
		$display("including zero, minimal and saturated brightness and a long output stall.");
		if (fail_count == 0) begin
			$display("[led_pixel_symbol_encoder] OK");
		end else begin
			$display("[led_pixel_symbol_encoder] ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake or symbols that never arrive.
	initial begin : watchdog
		#(LimitCycles * 2 * HalfPeriod);
		$display("[led_pixel_symbol_encoder] ERROR");
		$finish;
	end

endmodule

FILE: led_pixel_symbol_encoder.f
src/lpse_pkg.sv
src/lpse_front.sv
src/lpse_queue.sv
src/lpse_back.sv
src/led_pixel_symbol_encoder.sv
src/lpse_checker.sv
test/lpse_symbol_checker.sv
test/testbench.sv
